@@ hw/rtl/csds_pkg.sv @@
`default_nettype none

package csds_pkg;

  localparam int TARGET_W  = 32;
  localparam int CRYSTAL_W = 27;
  localparam int HS_W      = 4;
  localparam int N1_W      = 8;
  localparam int MULT_W    = 38;
  localparam int IMAGE_W   = 48;
  localparam int FDCO_W    = 33;
  localparam int FRAC_BITS = 28;
  localparam int NUM_W     = FDCO_W + FRAC_BITS;
  localparam int HS_IDX_W  = 3;

  localparam logic [FDCO_W-1:0]    FDCO_LOW      = 33'd4850000000;
  localparam logic [FDCO_W-1:0]    FDCO_HIGH     = 33'd5670000000;
  localparam logic [CRYSTAL_W-1:0] CRYSTAL_RESET = 27'd114285000;
  localparam logic [HS_IDX_W-1:0]  HS_LAST       = 3'd5;
  localparam logic [HS_W-1:0]      HS_BASE       = 4'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // High-speed dividers in search order.
  function automatic logic [HS_W-1:0] hs_lookup(input logic [HS_IDX_W-1:0] idx);
    logic [HS_W-1:0] hs;
    unique case (idx)
      3'd0:    hs = 4'd11;
      3'd1:    hs = 4'd9;
      3'd2:    hs = 4'd7;
      3'd3:    hs = 4'd6;
      3'd4:    hs = 4'd5;
      default: hs = 4'd4;
    endcase
    return hs;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/csds_in_if.sv @@
`default_nettype none

interface csds_in_if;
  logic                           valid;
  logic                           ready;
  logic [csds_pkg::TARGET_W-1:0]  target_hz;

  modport source (output valid, output target_hz, input ready);
  modport sink   (input valid, input target_hz, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/csds_out_if.sv @@
`default_nettype none

interface csds_out_if;
  logic                          valid;
  logic                          ready;
  logic                          error;
  logic [csds_pkg::HS_W-1:0]     high_speed_div;
  logic [csds_pkg::N1_W-1:0]     output_div;
  logic [csds_pkg::MULT_W-1:0]   multiplier;
  logic [csds_pkg::IMAGE_W-1:0]  register_image;

  modport source (output valid, output error, output high_speed_div, output output_div,
                  output multiplier, output register_image, input ready);
  modport sink   (input valid, input error, input high_speed_div, input output_div,
                  input multiplier, input register_image, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/csds_div.sv @@
`default_nettype none

module csds_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [csds_pkg::FDCO_W-1:0]    fdco_i,
  input  logic [csds_pkg::CRYSTAL_W-1:0] crystal_i,
  output csds_pkg::div_stat_t            stat_o,
  output logic [csds_pkg::MULT_W-1:0]    quot_o
);
  import csds_pkg::*;

  localparam int CntW = $clog2(NUM_W);
  localparam logic [CntW-1:0] CntLast = CntW'(NUM_W - 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CntW-1:0]      cnt_q;
  logic [NUM_W-1:0]     work_q;
  logic [CRYSTAL_W-1:0] rem_q;

  logic [CRYSTAL_W:0]   trial;
  logic [CRYSTAL_W:0]   divisor;
  logic [CRYSTAL_W:0]   diff;
  logic                 ge;
  logic                 overflow;

  // Restoring division, one quotient bit per cycle. The numerator shifts out
  // of the top of work_q while quotient bits shift in at the bottom.
  assign trial   = {rem_q, work_q[NUM_W-1]};
  assign divisor = {1'b0, crystal_i};
  assign ge      = (trial >= divisor);
  assign diff    = trial - divisor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      work_q <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntLast;
        work_q <= {fdco_i, {FRAC_BITS{1'b0}}};
        rem_q  <= '0;
      end else if (busy_q) begin
        work_q <= {work_q[NUM_W-2:0], ge};
        rem_q  <= ge ? diff[CRYSTAL_W-1:0] : trial[CRYSTAL_W-1:0];
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // A zero crystal or a quotient that does not fit saturates to all ones.
  assign overflow = (crystal_i == '0) || (|work_q[NUM_W-1:MULT_W]);
  assign quot_o   = overflow ? '1 : work_q[MULT_W-1:0];
  assign stat_o   = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

@@ hw/rtl/clock_synth_divider_search.sv @@
// Channel   Dir  Handshake            Payload
// target_i  in   valid/ready          target_hz[31:0]
// result_o  out  valid/ready          error, high_speed_div[3:0], output_div[7:0],
//                                     multiplier[37:0], register_image[47:0]
// cfg       in   cfg_we_i (no ready)  cfg_wdata_i[26:0] = crystal_hz
//
// One item at a time. For each high-speed divider ST_LOAD forms f*hs, and then
// ST_SCAN tries one N1 candidate per cycle until the DCO exceeds its upper
// limit or N1 runs past N1_LIMIT. The RFREQ divider then forms the quotient,
// one bit per cycle.
// Reset sets the crystal to 114285000 Hz; there is no clearing pass.
// A waiting result does not block the next transaction on target_i; a second
// result waits in ST_RESULT and holds target_i off until the first is taken.
`default_nettype none

module clock_synth_divider_search #(
  parameter int unsigned N1_LIMIT = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [csds_pkg::CRYSTAL_W-1:0] cfg_wdata_i,
  csds_in_if.sink                        target_i,
  csds_out_if.source                     result_o
);
  import csds_pkg::*;

  localparam int AccW = TARGET_W + HS_W + $clog2(N1_LIMIT + 2);
  localparam logic [N1_W:0] N1Max = (N1_W + 1)'(N1_LIMIT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_RESULT
  } state_e;

  state_e               state_q;
  logic [CRYSTAL_W-1:0] crystal_q;
  logic [TARGET_W-1:0]  f_q;
  logic [HS_IDX_W-1:0]  hs_idx_q;
  logic [AccW-1:0]      fhs_q;
  logic [AccW-1:0]      acc_q;
  logic [N1_W-1:0]      n1_q;
  logic                 found_q;
  logic [FDCO_W-1:0]    best_q;
  logic [HS_W-1:0]      best_hs_q;
  logic [N1_W-1:0]      best_n1_q;

  logic                 rsp_valid_q;
  logic                 rsp_error_q;
  logic [HS_W-1:0]      rsp_hs_q;
  logic [N1_W-1:0]      rsp_n1_q;
  logic [MULT_W-1:0]    rsp_mult_q;
  logic [IMAGE_W-1:0]   rsp_image_q;

  logic [HS_W-1:0]          hs_cur;
  logic [TARGET_W+HS_W-1:0] fhs_prod;
  logic                     acc_high;
  logic                     cand_ok;
  logic                     better;
  logic [N1_W:0]            n1_next;
  logic [AccW-1:0]          acc_step;
  logic                     hs_end;
  logic                     div_start;
  div_stat_t                div_stat;
  logic [MULT_W-1:0]        quot;
  logic                     out_free;
  logic                     rsp_load;
  logic [N1_W-1:0]          n1m;
  logic [HS_W-1:0]          hs_code;
  logic [IMAGE_W-1:0]       image;

  assign hs_cur   = hs_lookup(hs_idx_q);
  assign fhs_prod = f_q * hs_cur;

  // Candidates below the DCO range are simply skipped, so the scan may start
  // at N1 = 1 for every divider without changing the chosen pair. N1 = 1 is
  // only a candidate when f*hs lies above the lower limit, so for N1 = 1 a DCO
  // exactly on that limit does not count.
  assign acc_high = (acc_q > AccW'(FDCO_HIGH));
  assign cand_ok  = ((n1_q == N1_W'(1)) ? (acc_q > AccW'(FDCO_LOW))
                                        : (acc_q >= AccW'(FDCO_LOW))) && !acc_high;
  assign better   = cand_ok && (!found_q || (acc_q[FDCO_W-1:0] < best_q));
  assign n1_next  = (n1_q == N1_W'(1)) ? (N1_W + 1)'(2) : ({1'b0, n1_q} + (N1_W + 1)'(2));
  assign acc_step = acc_q + ((n1_q == N1_W'(1)) ? fhs_q : {fhs_q[AccW-2:0], 1'b0});
  assign hs_end   = acc_high || (n1_next > N1Max);

  assign div_start = (state_q == ST_DIV_START) && found_q && !div_stat.busy;
  assign out_free  = !rsp_valid_q || result_o.ready;
  assign rsp_load  = (state_q == ST_RESULT) && out_free;

  csds_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .fdco_i    (best_q),
    .crystal_i (crystal_q),
    .stat_o    (div_stat),
    .quot_o    (quot)
  );

  assign n1m     = best_n1_q - N1_W'(1);
  assign hs_code = best_hs_q - HS_BASE;
  assign image   = {hs_code[2:0], n1m[6:2], n1m[1:0], quot[MULT_W-1:32], quot[31:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      crystal_q   <= CRYSTAL_RESET;
      f_q         <= '0;
      hs_idx_q    <= '0;
      fhs_q       <= '0;
      acc_q       <= '0;
      n1_q        <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      best_hs_q   <= '0;
      best_n1_q   <= '0;
      rsp_valid_q <= 1'b0;
      rsp_error_q <= 1'b0;
      rsp_hs_q    <= '0;
      rsp_n1_q    <= '0;
      rsp_mult_q  <= '0;
      rsp_image_q <= '0;
    end else begin
      if (cfg_we_i) begin
        crystal_q <= cfg_wdata_i;
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && result_o.ready) begin
        rsp_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (target_i.valid) begin
            f_q      <= target_i.target_hz;
            hs_idx_q <= '0;
            found_q  <= 1'b0;
            state_q  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          fhs_q   <= AccW'(fhs_prod);
          acc_q   <= AccW'(fhs_prod);
          n1_q    <= N1_W'(1);
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (better) begin
            found_q   <= 1'b1;
            best_q    <= acc_q[FDCO_W-1:0];
            best_hs_q <= hs_cur;
            best_n1_q <= n1_q;
          end
          if (hs_end) begin
            if (hs_idx_q == HS_LAST) begin
              state_q <= ST_DIV_START;
            end else begin
              hs_idx_q <= hs_idx_q + 1'b1;
              state_q  <= ST_LOAD;
            end
          end else begin
            n1_q  <= n1_next[N1_W-1:0];
            acc_q <= acc_step;
          end
        end
        ST_DIV_START: begin
          if (!found_q) begin
            state_q <= ST_RESULT;
          end else if (!div_stat.busy) begin
            state_q <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_stat.done) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            if (found_q) begin
              rsp_error_q <= 1'b0;
              rsp_hs_q    <= best_hs_q;
              rsp_n1_q    <= best_n1_q;
              rsp_mult_q  <= quot;
              rsp_image_q <= image;
            end else begin
              rsp_error_q <= 1'b1;
              rsp_hs_q    <= '0;
              rsp_n1_q    <= '0;
              rsp_mult_q  <= '0;
              rsp_image_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign target_i.ready          = (state_q == ST_IDLE);
  assign result_o.valid          = rsp_valid_q;
  assign result_o.error          = rsp_error_q;
  assign result_o.high_speed_div = rsp_hs_q;
  assign result_o.output_div     = rsp_n1_q;
  assign result_o.multiplier     = rsp_mult_q;
  assign result_o.register_image = rsp_image_q;

endmodule

`default_nettype wire

@@ hw/rtl/csds_checker.sv @@
`default_nettype none

module csds_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          error_i,
  input logic [csds_pkg::HS_W-1:0]     hs_i,
  input logic [csds_pkg::N1_W-1:0]     n1_i,
  input logic [csds_pkg::MULT_W-1:0]   mult_i,
  input logic [csds_pkg::IMAGE_W-1:0]  image_i
);
  import csds_pkg::*;

  // A result that is not taken stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(error_i) && $stable(hs_i)
      && $stable(n1_i) && $stable(mult_i) && $stable(image_i))
    else $error("result changed while stalled");

  // Once a target is taken the block is busy for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transaction");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_i |-> hs_i == '0 && n1_i == '0 && mult_i == '0 && image_i == '0)
    else $error("error result with nonzero fields");

  a_divider_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !error_i |->
      (hs_i == 4'd4 || hs_i == 4'd5 || hs_i == 4'd6 || hs_i == 4'd7 || hs_i == 4'd9
        || hs_i == 4'd11) && (n1_i == 8'd1 || (n1_i != '0 && !n1_i[0])))
    else $error("illegal divider pair");

  a_image_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !error_i |->
      image_i[37:32] == mult_i[MULT_W-1:32] && image_i[31:0] == mult_i[31:0])
    else $error("register image disagrees with multiplier");

endmodule

bind clock_synth_divider_search csds_checker u_csds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (target_i.valid),
  .in_ready_i  (target_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .error_i     (result_o.error),
  .hs_i        (result_o.high_speed_div),
  .n1_i        (result_o.output_div),
  .mult_i      (result_o.multiplier),
  .image_i     (result_o.register_image)
);

`default_nettype wire

@@ tb/sv/clock_synth_divider_search_tb.sv @@
`timescale 1ns / 1ps

module clock_synth_divider_search_tb;

  import csds_pkg::TARGET_W;
  import csds_pkg::CRYSTAL_W;
  import csds_pkg::HS_W;
  import csds_pkg::N1_W;
  import csds_pkg::MULT_W;
  import csds_pkg::IMAGE_W;
  import csds_pkg::CRYSTAL_RESET;

  localparam int unsigned N1_MAX = 128;
  localparam longint unsigned DCO_MIN_HZ = 64'd4850000000;
  localparam longint unsigned DCO_MAX_HZ = 64'd5670000000;
  localparam longint unsigned RFREQ_SAT = (64'd1 << 38) - 64'd1;
  localparam int unsigned HS_ORDER[6] = '{11, 9, 7, 6, 5, 4};
  localparam int unsigned IDLE_PCT = 22;
  localparam int unsigned DRAIN_CYCLES = 600;

  typedef struct packed {
    logic                error;
    logic [HS_W-1:0]     high_speed_div;
    logic [N1_W-1:0]     output_div;
    logic [MULT_W-1:0]   multiplier;
    logic [IMAGE_W-1:0]  register_image;
  } synth_setting_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CRYSTAL_W-1:0] cfg_wdata;

  csds_in_if  target_if ();
  csds_out_if result_if ();

  clock_synth_divider_search #(
    .N1_LIMIT(N1_MAX)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .target_i   (target_if),
    .result_o   (result_if)
  );

  synth_setting_t       pending_settings[$];
  logic [CRYSTAL_W-1:0] crystal_shadow;
  int unsigned          targets_sent;
  int unsigned          settings_checked;
  int unsigned          crystal_settings;
  int unsigned          mismatches;
  int unsigned          hold_request;
  bit                   steady_flow;

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  // Divider search as the block should perform it, in 64-bit integer arithmetic.
  function automatic synth_setting_t predict_synth_setting(input logic [TARGET_W-1:0] target,
                                                           input logic [CRYSTAL_W-1:0] xtal);
    synth_setting_t  r;
    longint unsigned f;
    longint unsigned hs;
    longint unsigned n1;
    longint unsigned fdco;
    longint unsigned best_dco;
    longint unsigned best_hs;
    longint unsigned best_n1;
    longint unsigned rfreq;
    longint unsigned n1m;
    logic [7:0]      reg7;
    logic [7:0]      reg8;
    bit              found;
    r = '0;
    r.error = 1'b1;
    found = 1'b0;
    best_dco = 0;
    best_hs = 0;
    best_n1 = 0;
    if (target == '0) return r;
    f = 64'(target);
    for (int i = 0; i < 6; i++) begin
      hs = 64'(HS_ORDER[i]);
      n1 = (DCO_MIN_HZ / hs) / f;
      if (n1 == 0 || (n1 & 64'd1) != 0) n1++;
      while (n1 <= 64'(N1_MAX)) begin
        fdco = f * hs * n1;
        if (fdco > DCO_MAX_HZ) break;
        // A strictly lower DCO is needed to replace the pair found first.
        if (fdco >= DCO_MIN_HZ && (!found || fdco < best_dco)) begin
          found = 1'b1;
          best_dco = fdco;
          best_hs = hs;
          best_n1 = n1;
        end
        n1 += (n1 == 1) ? 1 : 2;
      end
    end
    if (!found) return r;
    if (xtal == '0) begin
      rfreq = RFREQ_SAT;
    end else begin
      rfreq = (best_dco << 28) / 64'(xtal);
      if (rfreq > RFREQ_SAT) rfreq = RFREQ_SAT;
    end
    n1m = best_n1 - 1;
    reg7 = 8'((((best_hs - 4) << 5) | ((n1m >> 2) & 64'h1f)) & 64'hff);
    reg8 = 8'((((n1m & 64'd3) << 6) | ((rfreq >> 32) & 64'h3f)) & 64'hff);
    r.error = 1'b0;
    r.high_speed_div = HS_W'(best_hs);
    r.output_div = N1_W'(best_n1);
    r.multiplier = MULT_W'(rfreq);
    r.register_image = {reg7, reg8, rfreq[31:0]};
    return r;
  endfunction

  function automatic logic [TARGET_W-1:0] rand_target();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) begin
      case ($urandom_range(3))
        0:       return $urandom_range(20000000, 3444603);
        1:       return $urandom_range(150000000, 20000000);
        2:       return $urandom_range(600000000, 150000000);
        default: return $urandom_range(1417500000, 600000000);
      endcase
    end else if (sel < 80) begin
      return $urandom_range(3444602, 0);
    end else if (sel < 88) begin
      return $urandom_range(32'hffff_ffff, 1417500001);
    end else if (sel < 98) begin
      return $urandom();
    end
    return '0;
  endfunction

  // Leaves valid high after the transaction so that back-to-back items need no gap.
  task automatic send_target(input logic [TARGET_W-1:0] target);
    int unsigned gap;
    gap = 0;
    if (!steady_flow) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    @(negedge clk);
    if (gap > 0) begin
      target_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    target_if.valid <= 1'b1;
    target_if.target_hz <= target;
    do @(posedge clk); while (!target_if.ready);
    pending_settings.push_back(predict_synth_setting(target, crystal_shadow));
    targets_sent++;
  endtask

  task automatic settle_targets();
    @(negedge clk);
    target_if.valid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
  endtask

  task automatic write_crystal(input logic [CRYSTAL_W-1:0] value);
    settle_targets();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    crystal_shadow = value;
    crystal_settings++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic report_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    synth_setting_t want;
    synth_setting_t got;
    if (result_if.valid && result_if.ready) begin
      got = {result_if.error, result_if.high_speed_div, result_if.output_div,
             result_if.multiplier, result_if.register_image};
      if (pending_settings.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        mismatches++;
      end else begin
        want = pending_settings.pop_front();
        settings_checked++;
        if (got !== want) begin
          mismatches++;
          report_field("error", 64'(want.error), 64'(got.error));
          report_field("high_speed_div", 64'(want.high_speed_div), 64'(got.high_speed_div));
          report_field("output_div", 64'(want.output_div), 64'(got.output_div));
          report_field("multiplier", 64'(want.multiplier), 64'(got.multiplier));
          report_field("register_image", 64'(want.register_image), 64'(got.register_image));
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever a test asks for one.
  always @(negedge clk) begin
    int unsigned hold_left;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic test_reset_crystal();
    logic [TARGET_W-1:0] targets[18];
    targets = '{32'd0, 32'd1, 32'd3444602, 32'd3444603, 32'd10000000,
                // Both of these reach the same DCO through two divider pairs.
                32'd144444444, 32'd208333333,
                32'd156250000, 32'd440909091, 32'd515454545,
                // This one falls in the gap between the ranges of two dividers.
                32'd520000000,
                // With N1 = 1 these land exactly on the lower DCO limit.
                32'd970000000, 32'd1212500000,
                32'd1417500000, 32'd1417500001, 32'h8000_0000, 32'hffff_ffff,
                32'h5555_5555};
    foreach (targets[i]) send_target(targets[i]);
  endtask

  task automatic test_crystal_extremes();
    logic [CRYSTAL_W-1:0] crystals[5];
    crystals = '{27'd100000000, 27'd130000000, 27'd0, 27'd1, 27'h7ff_ffff};
    foreach (crystals[i]) begin
      write_crystal(crystals[i]);
      send_target(32'd10000000);
      send_target(32'd1417500000);
    end
  endtask

  task automatic test_result_backpressure();
    write_crystal(CRYSTAL_RESET);
    hold_request = 2500;
    repeat (12) send_target(rand_target());
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 3) begin
        write_crystal(CRYSTAL_W'($urandom_range(27'h7ff_ffff)));
      end else begin
        write_crystal(CRYSTAL_W'($urandom_range(130000000, 100000000)));
      end
      steady_flow = (phase == 5);
      repeat (135) send_target(rand_target());
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    target_if.valid = 1'b0;
    target_if.target_hz = '0;
    result_if.ready = 1'b0;
    crystal_shadow = CRYSTAL_RESET;
    targets_sent = 0;
    settings_checked = 0;
    crystal_settings = 1;
    mismatches = 0;
    hold_request = 0;
    steady_flow = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_crystal();
    test_crystal_extremes();
    test_result_backpressure();
    test_random_traffic();

    settle_targets();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_settings.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_settings.size());
      mismatches++;
    end
    $display("Checked %0d divider settings for %0d targets under %0d crystal settings,",
             settings_checked, targets_sent, crystal_settings);
    $display("including zero, tiny and full-scale crystals and a long result stall.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_settings.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ clock_synth_divider_search.f @@
hw/rtl/csds_pkg.sv
hw/rtl/csds_in_if.sv
hw/rtl/csds_out_if.sv
hw/rtl/csds_div.sv
hw/rtl/clock_synth_divider_search.sv
hw/rtl/csds_checker.sv
tb/sv/clock_synth_divider_search_tb.sv
